FILE: design/wosc_pkg.sv
// Shared constants and types for the wavetable oscillator.
// Used by the front, back, output queue and top level. No dependencies.
package wosc_pkg;

	localparam int TABLE_SIZE_DEF = 1024;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int CFG_W   = 24;
	localparam int ADDR_W  = 10;
	localparam int VALUE_W = 16;
	localparam int FREQ_W  = 15;
	localparam int GAIN_W  = 16;
	localparam int RAW_W   = FREQ_W + CFG_W;
	localparam int RAW_FRAC = 16;

	localparam logic [CFG_W-1:0] STEP_PER_HZ_RST = 24'd1398;

	localparam int QUEUE_DEPTH = 2;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef struct packed {
		logic is_load;
		logic last;
	} wosc_tag_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] sample;
		logic                      last;
	} wosc_res_t;

endpackage

FILE: design/wosc_front.sv
// Front end: holds the step register, accepts words, drops loads outside the
// table, forms the raw phase step and queues words for the back end.
// Depends on wosc_pkg.
module wosc_front #(
	parameter int TABLE_SIZE = wosc_pkg::TABLE_SIZE_DEF,
	parameter int AW         = $clog2(TABLE_SIZE)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [wosc_pkg::CFG_W-1:0]          cfg_wr_data,
	input  logic                                push,
	output logic                                full,
	input  logic                                cmd,
	input  logic [wosc_pkg::ADDR_W-1:0]         table_addr,
	input  logic signed [wosc_pkg::VALUE_W-1:0] table_value,
	input  logic [wosc_pkg::FREQ_W-1:0]         frequency_hz,
	input  logic [wosc_pkg::GAIN_W-1:0]         gain,
	input  logic                                block_last,
	output logic                                fq_empty,
	input  logic                                fq_pop,
	output wosc_pkg::wosc_tag_t                 head_tag,
	output logic [AW-1:0]                       head_addr,
	output logic signed [wosc_pkg::VALUE_W-1:0] head_value,
	output logic [wosc_pkg::RAW_W-1:0]          head_raw,
	output logic [wosc_pkg::GAIN_W-1:0]         head_gain
);

	localparam int QD  = wosc_pkg::QUEUE_DEPTH;
	localparam int QAW = (QD > 1) ? $clog2(QD) : 1;

	logic [wosc_pkg::CFG_W-1:0] step_per_hz_q;

	wosc_pkg::wosc_tag_t               tag_q   [QD];
	logic [AW-1:0]                     addr_q  [QD];
	logic signed [wosc_pkg::VALUE_W-1:0] value_q [QD];
	logic [wosc_pkg::RAW_W-1:0]        raw_q   [QD];
	logic [wosc_pkg::GAIN_W-1:0]       gain_q  [QD];

	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	logic                       accept;
	logic                       addr_ok;
	logic                       enq;
	logic                       deq;
	logic [wosc_pkg::RAW_W-1:0] raw;
	wosc_pkg::wosc_tag_t        in_tag;

	assign full     = (count_q == (QAW+1)'(QD));
	assign fq_empty = (count_q == '0);
	assign accept   = push && !full;
	assign addr_ok  = (32'(table_addr) < TABLE_SIZE);
	assign enq      = accept && ((cmd == wosc_pkg::CMD_SAMPLE) || addr_ok);
	assign deq      = fq_pop && !fq_empty;

	assign raw = wosc_pkg::RAW_W'(frequency_hz) * wosc_pkg::RAW_W'(step_per_hz_q);

	always_comb begin
		in_tag.is_load = (cmd == wosc_pkg::CMD_LOAD);
		in_tag.last    = block_last;
	end

	assign head_tag   = tag_q[rd_ptr_q];
	assign head_addr  = addr_q[rd_ptr_q];
	assign head_value = value_q[rd_ptr_q];
	assign head_raw   = raw_q[rd_ptr_q];
	assign head_gain  = gain_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_per_hz_q <= wosc_pkg::STEP_PER_HZ_RST;
		end else if (cfg_wr_en) begin
			step_per_hz_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QD-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QD-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				count_q <= count_q + 1'b1;
			end else if (deq && !enq) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			tag_q[wr_ptr_q]   <= in_tag;
			addr_q[wr_ptr_q]  <= AW'(table_addr);
			value_q[wr_ptr_q] <= table_value;
			raw_q[wr_ptr_q]   <= raw;
			gain_q[wr_ptr_q]  <= gain;
		end
	end

endmodule

FILE: design/wosc_back.sv
// Back end: wave table memory, phase accumulator and the sequencer that
// reads two entries, interpolates, scales and saturates one sample, or
// gives zero before any load. Depends on wosc_pkg.
module wosc_back #(
	parameter int TABLE_SIZE = wosc_pkg::TABLE_SIZE_DEF,
	parameter int FRAC_BITS  = wosc_pkg::FRAC_BITS_DEF,
	parameter int AW         = $clog2(TABLE_SIZE)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                fq_empty,
	output logic                                fq_pop,
	input  wosc_pkg::wosc_tag_t                 head_tag,
	input  logic [AW-1:0]                       head_addr,
	input  logic signed [wosc_pkg::VALUE_W-1:0] head_value,
	input  logic [wosc_pkg::RAW_W-1:0]          head_raw,
	input  logic [wosc_pkg::GAIN_W-1:0]         head_gain,
	output logic                                oq_push,
	input  logic                                oq_full,
	output wosc_pkg::wosc_res_t                 res
);

	localparam int PW     = AW + FRAC_BITS;
	localparam int LSH    = (FRAC_BITS >= wosc_pkg::RAW_FRAC) ? FRAC_BITS - wosc_pkg::RAW_FRAC : 0;
	localparam int RSH    = (FRAC_BITS <  wosc_pkg::RAW_FRAC) ? wosc_pkg::RAW_FRAC - FRAC_BITS : 0;
	localparam int STEP_W = wosc_pkg::RAW_W + LSH;
	localparam int CMP_W  = (STEP_W > PW) ? STEP_W : PW;
	localparam int P1_W   = wosc_pkg::VALUE_W + 1 + FRAC_BITS + 1;
	localparam int P2_W   = wosc_pkg::VALUE_W + wosc_pkg::GAIN_W + 1;

	localparam logic [PW:0]   PHASE_LEN = (PW+1)'(TABLE_SIZE) << FRAC_BITS;
	localparam logic [PW-1:0] PHASE_MAX = PW'(PHASE_LEN - 1'b1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RD1  = 6'b000010,
		ST_MUL1 = 6'b000100,
		ST_MUL2 = 6'b001000,
		ST_MUL3 = 6'b010000,
		ST_OUT  = 6'b100000
	} wosc_state_t;

	wosc_state_t state_q;
	logic        loaded_q;
	logic [PW-1:0] phase_q;

	logic signed [wosc_pkg::VALUE_W-1:0] mem [TABLE_SIZE];
	logic signed [wosc_pkg::VALUE_W-1:0] rdata_q;
	logic signed [wosc_pkg::VALUE_W-1:0] v0_q;
	logic signed [wosc_pkg::VALUE_W-1:0] interp_q;
	logic [wosc_pkg::RAW_W-1:0]          raw_q;
	logic [wosc_pkg::GAIN_W-1:0]         gain_q;
	logic                                last_q;
	logic [PW-1:0]                       step_q;
	logic signed [P1_W-1:0]              prod1_q;
	logic signed [P2_W-1:0]              prod2_q;

	logic                       mem_we;
	logic [AW-1:0]              idx0;
	logic [AW-1:0]              idx1;
	logic [AW-1:0]              raddr;
	logic [FRAC_BITS-1:0]       frac;
	logic [STEP_W-1:0]          step_wide;
	logic [PW-1:0]              step_sat;
	logic [PW:0]                phase_sum;
	logic [PW-1:0]              phase_next;
	logic signed [wosc_pkg::VALUE_W:0] diff;
	logic signed [P1_W-1:0]     prod1;
	logic signed [P1_W-1:0]     interp_sum;
	logic signed [P2_W-1:0]     scaled;
	logic signed [wosc_pkg::VALUE_W-1:0] sat_val;

	assign fq_pop  = (state_q == ST_IDLE) && !fq_empty;
	assign mem_we  = fq_pop && head_tag.is_load;
	assign oq_push = (state_q == ST_OUT) && !oq_full;

	assign idx0  = phase_q[PW-1:FRAC_BITS];
	assign idx1  = ((AW+1)'(idx0) + 1'b1 == (AW+1)'(TABLE_SIZE)) ? '0 : idx0 + 1'b1;
	assign raddr = (state_q == ST_RD1) ? idx1 : idx0;
	assign frac  = phase_q[FRAC_BITS-1:0];

	always_comb begin
		step_wide = (STEP_W'(raw_q) << LSH) >> RSH;
		if (CMP_W'(step_wide) > CMP_W'(PHASE_MAX)) begin
			step_sat = PHASE_MAX;
		end else begin
			step_sat = PW'(step_wide);
		end
	end

	always_comb begin
		phase_sum = {1'b0, phase_q} + {1'b0, step_q};
		if (phase_sum >= PHASE_LEN) begin
			phase_next = PW'(phase_sum - PHASE_LEN);
		end else begin
			phase_next = phase_sum[PW-1:0];
		end
	end

	assign diff       = {rdata_q[wosc_pkg::VALUE_W-1], rdata_q} - {v0_q[wosc_pkg::VALUE_W-1], v0_q};
	assign prod1      = diff * $signed({1'b0, frac});
	assign interp_sum = P1_W'(v0_q) + (prod1_q >>> FRAC_BITS);
	assign scaled     = prod2_q >>> 15;

	always_comb begin
		if (scaled > P2_W'(32767)) begin
			sat_val = 16'sh7fff;
		end else if (scaled < -P2_W'(32768)) begin
			sat_val = -16'sh8000;
		end else begin
			sat_val = scaled[wosc_pkg::VALUE_W-1:0];
		end
	end

	always_comb begin
		res.sample = sat_val;
		res.last   = last_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[head_addr] <= head_value;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			loaded_q <= 1'b0;
			phase_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (fq_pop) begin
						if (head_tag.is_load) begin
							loaded_q <= 1'b1;
						end else if (loaded_q) begin
							state_q <= ST_RD1;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_RD1:  state_q <= ST_MUL1;
				ST_MUL1: begin
					phase_q <= phase_next;
					state_q <= ST_MUL2;
				end
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_OUT;
				ST_OUT: begin
					if (!oq_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fq_pop && !head_tag.is_load) begin
			raw_q  <= head_raw;
			gain_q <= head_gain;
			last_q <= head_tag.last;
			if (!loaded_q) begin
				prod2_q <= '0;
			end
		end
		if (state_q == ST_RD1) begin
			v0_q   <= rdata_q;
			step_q <= step_sat;
		end
		if (state_q == ST_MUL1) begin
			prod1_q <= prod1;
		end
		if (state_q == ST_MUL2) begin
			interp_q <= interp_sum[wosc_pkg::VALUE_W-1:0];
		end
		if (state_q == ST_MUL3) begin
			prod2_q <= interp_q * $signed({1'b0, gain_q});
		end
	end

endmodule

FILE: design/wosc_outq.sv
// Result queue: a short FIFO of finished samples in front of the result
// ports, so the back end can finish a word while the consumer stalls.
// Depends on wosc_pkg.
module wosc_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                oq_push,
	output logic                oq_full,
	input  wosc_pkg::wosc_res_t res,
	output logic                empty,
	input  logic                pop,
	output wosc_pkg::wosc_res_t head
);

	localparam int QD  = wosc_pkg::QUEUE_DEPTH;
	localparam int QAW = (QD > 1) ? $clog2(QD) : 1;

	wosc_pkg::wosc_res_t data_q [QD];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	logic enq;
	logic deq;

	assign oq_full = (count_q == (QAW+1)'(QD));
	assign empty   = (count_q == '0);
	assign enq     = oq_push && !oq_full;
	assign deq     = pop && !empty;
	assign head    = data_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QD-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QD-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				count_q <= count_q + 1'b1;
			end else if (deq && !enq) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			data_q[wr_ptr_q] <= res;
		end
	end

endmodule

FILE: design/wavetable_oscillator_interp.sv
// Top level of the wavetable oscillator with linear interpolation.
// Depends on wosc_pkg, wosc_front, wosc_back and wosc_outq.
//
//   channel   handshake            payload
//   input     push / full          cmd, table_addr, table_value, frequency_hz, gain, block_last
//   result    empty / pop          sample_out, last_sample
//   config    cfg_wr_en            cfg_wr_data (step_per_hz)
//
// A load word writes the table when popped; a loaded sample word takes two
// table reads on the single read port, two multiplies, scale and an output
// push. Words are registered in the front queue. Reset clears the phase, the
// loaded flag, both queues and sets step_per_hz to 1398; the table is not
// cleared. Two-word queues on each side let input and result stall apart.
module wavetable_oscillator_interp #(
	parameter int TABLE_SIZE = wosc_pkg::TABLE_SIZE_DEF,
	parameter int FRAC_BITS  = wosc_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [wosc_pkg::CFG_W-1:0]          cfg_wr_data,
	input  logic                                push,
	output logic                                full,
	input  logic                                cmd,
	input  logic [wosc_pkg::ADDR_W-1:0]         table_addr,
	input  logic signed [wosc_pkg::VALUE_W-1:0] table_value,
	input  logic [wosc_pkg::FREQ_W-1:0]         frequency_hz,
	input  logic [wosc_pkg::GAIN_W-1:0]         gain,
	input  logic                                block_last,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [wosc_pkg::VALUE_W-1:0] sample_out,
	output logic                                last_sample
);

	localparam int AW = $clog2(TABLE_SIZE);

	logic                                fq_empty;
	logic                                fq_pop;
	wosc_pkg::wosc_tag_t                 head_tag;
	logic [AW-1:0]                       head_addr;
	logic signed [wosc_pkg::VALUE_W-1:0] head_value;
	logic [wosc_pkg::RAW_W-1:0]          head_raw;
	logic [wosc_pkg::GAIN_W-1:0]         head_gain;
	logic                                oq_push;
	logic                                oq_full;
	wosc_pkg::wosc_res_t                 res;
	wosc_pkg::wosc_res_t                 res_head;

	wosc_front #(
		.TABLE_SIZE(TABLE_SIZE),
		.AW        (AW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.push        (push),
		.full        (full),
		.cmd         (cmd),
		.table_addr  (table_addr),
		.table_value (table_value),
		.frequency_hz(frequency_hz),
		.gain        (gain),
		.block_last  (block_last),
		.fq_empty    (fq_empty),
		.fq_pop      (fq_pop),
		.head_tag    (head_tag),
		.head_addr   (head_addr),
		.head_value  (head_value),
		.head_raw    (head_raw),
		.head_gain   (head_gain)
	);

	wosc_back #(
		.TABLE_SIZE(TABLE_SIZE),
		.FRAC_BITS (FRAC_BITS),
		.AW        (AW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fq_empty  (fq_empty),
		.fq_pop    (fq_pop),
		.head_tag  (head_tag),
		.head_addr (head_addr),
		.head_value(head_value),
		.head_raw  (head_raw),
		.head_gain (head_gain),
		.oq_push   (oq_push),
		.oq_full   (oq_full),
		.res       (res)
	);

	wosc_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.oq_push(oq_push),
		.oq_full(oq_full),
		.res    (res),
		.empty  (empty),
		.pop    (pop),
		.head   (res_head)
	);

	assign sample_out  = res_head.sample;
	assign last_sample = res_head.last;

endmodule

FILE: tb/wosc_checker.sv
`timescale 1ns / 1ps
// Checker for the wavetable oscillator: mirrors table, phase and step_per_hz
// from the observed config and input words and compares popped results in order.
// Depends on wosc_pkg.
module wosc_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [wosc_pkg::CFG_W-1:0]          cfg_wr_data,
	input  logic                                push,
	input  logic                                full,
	input  logic                                cmd,
	input  logic [wosc_pkg::ADDR_W-1:0]         table_addr,
	input  logic signed [wosc_pkg::VALUE_W-1:0] table_value,
	input  logic [wosc_pkg::FREQ_W-1:0]         frequency_hz,
	input  logic [wosc_pkg::GAIN_W-1:0]         gain,
	input  logic                                block_last,
	input  logic                                empty,
	input  logic                                pop,
	input  logic signed [wosc_pkg::VALUE_W-1:0] sample_out,
	input  logic                                last_sample,
	output int                                  fail_count,
	output int                                  pending
);

	localparam int FRAC_W    = wosc_pkg::FRAC_BITS_DEF;
	localparam int PHASE_W   = wosc_pkg::ADDR_W + FRAC_W;
	localparam int GAIN_FRAC = 15;
	localparam logic [PHASE_W-1:0] PHASE_MAX = '1;
	localparam longint SAT_HI = 32767;
	localparam longint SAT_LO = -32768;

	logic signed [wosc_pkg::VALUE_W-1:0] wave_copy [0:wosc_pkg::TABLE_SIZE_DEF-1];
	logic [PHASE_W-1:0]                  osc_phase;
	logic                                loaded;
	logic [wosc_pkg::CFG_W-1:0]          step_cfg;
	wosc_pkg::wosc_res_t                 expected_q [$];
	wosc_pkg::wosc_res_t                 want;
	int                                  errors;

	function automatic logic signed [wosc_pkg::VALUE_W-1:0] next_sample(
		input logic [wosc_pkg::FREQ_W-1:0] freq,
		input logic [wosc_pkg::GAIN_W-1:0] g
	);
		longint unsigned             raw;
		logic [PHASE_W-1:0]          step;
		logic [PHASE_W:0]            sum;
		logic [wosc_pkg::ADDR_W-1:0] idx0;
		logic [wosc_pkg::ADDR_W-1:0] idx1;
		longint                      v0;
		longint                      v1;
		longint                      frac;
		longint                      mix;
		longint                      scaled;
		if (!loaded)
			return '0;
		raw = longint'(freq) * longint'(step_cfg);
		if (raw > PHASE_MAX)
			step = PHASE_MAX;
		else
			step = raw[PHASE_W-1:0];
		idx0 = osc_phase[PHASE_W-1:FRAC_W];
		idx1 = idx0 + 1'b1;
		frac = longint'(osc_phase[FRAC_W-1:0]);
		v0 = wave_copy[idx0];
		v1 = wave_copy[idx1];
		mix = v0 + (((v1 - v0) * frac) >>> FRAC_W);
		scaled = (mix * longint'(g)) >>> GAIN_FRAC;
		if (scaled > SAT_HI)
			scaled = SAT_HI;
		else if (scaled < SAT_LO)
			scaled = SAT_LO;
		sum = {1'b0, osc_phase} + {1'b0, step};
		// wrap modulo table length
		sum[PHASE_W] = 1'b0;
		osc_phase = sum[PHASE_W-1:0];
		return scaled[wosc_pkg::VALUE_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osc_phase = '0;
			loaded = 1'b0;
			step_cfg = wosc_pkg::STEP_PER_HZ_RST;
			expected_q.delete();
			errors = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: result word with none expected, %s %0d %s %0b",
						$time, "actual sample_out", sample_out,
						"last_sample", last_sample);
				end else begin
					want = expected_q.pop_front();
					if (sample_out !== want.sample) begin
						errors++;
						$display("%0t: sample_out expected %0d, actual %0d",
							$time, want.sample, sample_out);
					end
					if (last_sample !== want.last) begin
						errors++;
						$display("%0t: last_sample expected %0b, actual %0b",
							$time, want.last, last_sample);
					end
				end
			end
			if (cfg_wr_en)
				step_cfg = cfg_wr_data;
			if (push && !full) begin
				if (cmd == wosc_pkg::CMD_LOAD) begin
					wave_copy[table_addr] = table_value;
					loaded = 1'b1;
				end else begin
					want.sample = next_sample(frequency_hz, gain);
					want.last = block_last;
					expected_q.push_back(want);
				end
			end
		end
		pending <= expected_q.size();
		fail_count <= errors;
	end

endmodule

FILE: tb/wavetable_oscillator_interp_tb.sv
`timescale 1ns / 1ps
// Top of the wavetable oscillator testbench: clock, reset, stimulus and verdict.
// Depends on wosc_pkg, wavetable_oscillator_interp and wosc_checker.
module wavetable_oscillator_interp_tb;

	localparam int  IDLE_WAIT = 32;
	localparam int  PHASE_ITEMS = 50;
	localparam int  HOLD_CYCLES = 200;
	localparam time RUN_LIMIT = 5_000_000;

	logic                                clk;
	logic                                arst_n = 1'b0;
	logic                                cfg_wr_en = 1'b0;
	logic [wosc_pkg::CFG_W-1:0]          cfg_wr_data = '0;
	logic                                push = 1'b0;
	logic                                full;
	logic                                cmd = wosc_pkg::CMD_LOAD;
	logic [wosc_pkg::ADDR_W-1:0]         table_addr = '0;
	logic signed [wosc_pkg::VALUE_W-1:0] table_value = '0;
	logic [wosc_pkg::FREQ_W-1:0]         frequency_hz = '0;
	logic [wosc_pkg::GAIN_W-1:0]         gain = '0;
	logic                                block_last = 1'b0;
	logic                                empty;
	logic                                pop = 1'b0;
	logic signed [wosc_pkg::VALUE_W-1:0] sample_out;
	logic                                last_sample;
	int                                  fail_count;
	int                                  pending;
	int                                  tx_count = 0;
	int                                  rx_count = 0;
	bit                                  tx_quiet = 1'b0;
	bit                                  rx_quiet = 1'b0;

	wavetable_oscillator_interp u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.table_addr   (table_addr),
		.table_value  (table_value),
		.frequency_hz (frequency_hz),
		.gain         (gain),
		.block_last   (block_last),
		.empty        (empty),
		.pop          (pop),
		.sample_out   (sample_out),
		.last_sample  (last_sample)
	);

	wosc_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.table_addr   (table_addr),
		.table_value  (table_value),
		.frequency_hz (frequency_hz),
		.gain         (gain),
		.block_last   (block_last),
		.empty        (empty),
		.pop          (pop),
		.sample_out   (sample_out),
		.last_sample  (last_sample),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("wavetable_oscillator_interp_tb: FAIL");
		$finish;
	end

	function automatic logic signed [wosc_pkg::VALUE_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			default: return wosc_pkg::VALUE_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [wosc_pkg::VALUE_W-1:0] fill_value(input int idx);
		if (idx == 0)
			return 16'sh7FFF;
		if (idx == 1 || idx == wosc_pkg::TABLE_SIZE_DEF - 1)
			return 16'sh8000;
		return rand_value();
	endfunction

	task automatic send_word(
		input logic                                c,
		input logic [wosc_pkg::ADDR_W-1:0]         a,
		input logic signed [wosc_pkg::VALUE_W-1:0] v,
		input logic [wosc_pkg::FREQ_W-1:0]         f,
		input logic [wosc_pkg::GAIN_W-1:0]         g,
		input logic                                l
	);
		int gap;
		if (tx_count % 40 == 0)
			tx_quiet = ($urandom_range(0, 3) == 0);
		gap = tx_quiet ? 0 : int'($urandom_range(0, 5));
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		cmd <= c;
		table_addr <= a;
		table_value <= v;
		frequency_hz <= f;
		gain <= g;
		block_last <= l;
		@(posedge clk);
		while (full) @(posedge clk);
		tx_count++;
	endtask

	task automatic load_word(input logic [wosc_pkg::ADDR_W-1:0] a,
		input logic signed [wosc_pkg::VALUE_W-1:0] v);
		send_word(wosc_pkg::CMD_LOAD, a, v, wosc_pkg::FREQ_W'($urandom),
			wosc_pkg::GAIN_W'($urandom), 1'($urandom));
	endtask

	task automatic sample_word(input logic [wosc_pkg::FREQ_W-1:0] f,
		input logic [wosc_pkg::GAIN_W-1:0] g, input logic l);
		send_word(wosc_pkg::CMD_SAMPLE, wosc_pkg::ADDR_W'($urandom),
			wosc_pkg::VALUE_W'($urandom), f, g, l);
	endtask

	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic set_step(input logic [wosc_pkg::CFG_W-1:0] v);
		drain_results();
		repeat (IDLE_WAIT) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_word();
		logic [wosc_pkg::FREQ_W-1:0] f;
		logic [wosc_pkg::GAIN_W-1:0] g;
		if ($urandom_range(0, 99) < 20) begin
			load_word(wosc_pkg::ADDR_W'($urandom), rand_value());
		end else begin
			case ($urandom_range(0, 4))
				0: f = wosc_pkg::FREQ_W'($urandom_range(0, 15));
				1, 2: f = wosc_pkg::FREQ_W'($urandom_range(0, 24000));
				3: f = 15'd24000;
				default: f = wosc_pkg::FREQ_W'($urandom);
			endcase
			case ($urandom_range(0, 4))
				0, 1: g = 16'd32768;
				2, 3: g = wosc_pkg::GAIN_W'($urandom_range(0, 32768));
				default: g = wosc_pkg::GAIN_W'($urandom);
			endcase
			sample_word(f, g, 1'($urandom_range(0, 1)));
		end
	endtask

	// receiver: random pop gaps, two long holds to back up the block
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (rx_count % 40 == 0)
				rx_quiet = ($urandom_range(0, 3) == 0);
			gap = rx_quiet ? 0 : int'($urandom_range(0, 5));
			if (rx_count == 40 || rx_count == 150)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			rx_count++;
		end
	end

	initial begin
		logic [wosc_pkg::CFG_W-1:0] step_list [6];
		int i;
		int p;
		int n;
		step_list[0] = 24'hFFFFFF;
		step_list[1] = 24'd0;
		step_list[2] = wosc_pkg::STEP_PER_HZ_RST;
		step_list[3] = 24'd1;
		step_list[4] = wosc_pkg::CFG_W'($urandom_range(1, 4096));
		step_list[5] = wosc_pkg::CFG_W'($urandom);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// table not loaded: zero output, phase holds
		sample_word(15'd24000, 16'hFFFF, 1'b1);
		sample_word(15'd0, 16'd32768, 1'b0);
		sample_word(15'd1, 16'd1, 1'b1);

		for (i = 0; i < wosc_pkg::TABLE_SIZE_DEF; i++)
			load_word(wosc_pkg::ADDR_W'(i), fill_value(i));

		// one table entry per hertz
		set_step(24'd65536);
		sample_word(15'd0, 16'hFFFF, 1'b1);
		sample_word(15'd0, 16'd0, 1'b0);
		sample_word(15'd1023, 16'd32768, 1'b1);
		sample_word(15'd0, 16'hFFFF, 1'b0);
		load_word(10'd1023, 16'sh7FFF);
		load_word(10'd0, 16'sh8000);
		sample_word(15'd0, 16'd32768, 1'b1);
		sample_word(15'h7FFF, 16'd32768, 1'b0);
		sample_word(15'd24000, 16'd32768, 1'b1);
		sample_word(15'd16384, 16'd1, 1'b1);
		load_word(10'd512, 16'sh0000);
		load_word(10'd341, 16'sh5555);
		load_word(10'd682, 16'shAAAA);
		sample_word(15'h2AAA, 16'd16384, 1'b0);
		sample_word(15'h5555, 16'hFFFF, 1'b1);
		sample_word(15'd4096, 16'd32767, 1'b0);
		sample_word(15'd3, 16'h8001, 1'b1);
		sample_word(15'd7, 16'h7FFF, 1'b0);

		for (p = 0; p < 6; p++) begin
			set_step(step_list[p]);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				random_word();
				if (p == 2 && n == PHASE_ITEMS / 2)
					drain_results();
			end
		end

		drain_results();
		repeat (IDLE_WAIT) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("wavetable_oscillator_interp_tb: PASS");
		else
			$display("wavetable_oscillator_interp_tb: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
design/wosc_pkg.sv
design/wosc_front.sv
design/wosc_back.sv
design/wosc_outq.sv
design/wavetable_oscillator_interp.sv
tb/wosc_checker.sv
tb/wavetable_oscillator_interp_tb.sv
